### design/gbns_pkg.sv
// ---------------------------------------------------------------------------
// gbns_pkg
// Shared constants, types and sequence helpers for the go-back-n sender.
// ---------------------------------------------------------------------------
`default_nettype none

package gbns_pkg;

    localparam int WINDOW       = 4;
    localparam int SEQ_SPACE    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_W   = $clog2(SEQ_SPACE);
    localparam int EFF_WIN = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
    localparam int PAY_W   = 64;
    localparam int STORE_W = PAYLOAD_BITS;

    localparam int ACK_LSB = PAY_W;
    localparam int OK_BIT  = PAY_W + SEQ_W;
    localparam int TAG_LSB = PAY_W + SEQ_W + 1;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    typedef logic [SEQ_W-1:0] t_seq;

    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_TIMEOUT = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } t_tmr;

    typedef struct packed {
        logic             last;
        logic             full;
        t_seq             start;
        t_seq             stop;
        t_tmr             tcmd;
        logic [PAY_W-1:0] pay;
        t_seq             seq;
        logic             pv;
        logic             acc;
    } t_res;

    typedef struct packed {
        logic run;
        logic wr;
        t_seq base;
        t_seq cnt;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_seq seq_add(t_seq a, t_seq b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SEQ_W+1)'(SEQ_SPACE)) begin
            s = s - (SEQ_W+1)'(SEQ_SPACE);
        end
        return s[SEQ_W-1:0];
    endfunction

    function automatic t_seq seq_sub(t_seq a, t_seq b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + (SEQ_W+1)'(SEQ_SPACE) - {1'b0, b};
        if (s >= (SEQ_W+1)'(SEQ_SPACE)) begin
            s = s - (SEQ_W+1)'(SEQ_SPACE);
        end
        return s[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/gbns_front.sv
// ---------------------------------------------------------------------------
// gbns_front
// Accepts items, keeps the window state and queues one command per item.
// ---------------------------------------------------------------------------
`default_nettype none

module gbns_front
    import gbns_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic [IN_USER_W-1:0] i_user,
    input  wire t_qstat               i_qstat,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    t_seq r_base, n_base;
    t_seq r_next, n_next;
    logic r_full, n_full;

    t_mode            mode;
    logic [PAY_W-1:0] payload;
    t_seq             ack;
    logic             ack_ok;
    t_seq             tag;
    t_seq             inflight;
    t_seq             ack_ofs;
    t_seq             new_base;

    assign mode    = t_mode'(i_user);
    assign payload = i_data[PAY_W-1:0];
    assign ack     = i_data[ACK_LSB +: SEQ_W];
    assign ack_ok  = i_data[OK_BIT];
    assign tag     = i_data[TAG_LSB +: SEQ_W];

    assign inflight = seq_sub(r_next, r_base);
    assign ack_ofs  = seq_sub(ack, r_base);
    assign new_base = seq_add(ack, t_seq'(1));

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.res.last = 1'b1;
        o_cmd.res.full = r_full;
        o_cmd.res.tcmd = TMR_NONE;
        n_base         = r_base;
        n_next         = r_next;
        n_full         = r_full;
        case (mode)
            MODE_SEND: begin
                if (!(r_full || ({1'b0, inflight} >= (SEQ_W+1)'(EFF_WIN)))) begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.res.acc = 1'b1;
                    o_cmd.res.pv  = 1'b1;
                    o_cmd.res.seq = r_next;
                    o_cmd.res.pay = PAY_W'(payload[STORE_W-1:0]);
                    if (inflight == '0) begin
                        o_cmd.res.tcmd  = TMR_START;
                        o_cmd.res.start = r_base;
                    end
                    n_next = seq_add(r_next, t_seq'(1));
                    n_full = (({1'b0, inflight} + 1'b1) >= (SEQ_W+1)'(EFF_WIN));
                    o_cmd.res.full = n_full;
                end
            end
            MODE_ACK: begin
                if (ack_ok && ({1'b0, ack} < (SEQ_W+1)'(SEQ_SPACE)) &&
                    (ack_ofs < inflight)) begin
                    o_cmd.res.acc  = 1'b1;
                    o_cmd.res.stop = r_base;
                    n_base         = new_base;
                    n_full         = 1'b0;
                    o_cmd.res.full = 1'b0;
                    if (new_base == r_next) begin
                        o_cmd.res.tcmd = TMR_STOP;
                    end else begin
                        o_cmd.res.tcmd  = TMR_RESTART;
                        o_cmd.res.start = new_base;
                    end
                end
            end
            MODE_TIMEOUT: begin
                o_cmd.res.acc   = 1'b1;
                o_cmd.res.tcmd  = TMR_RESTART;
                o_cmd.res.stop  = tag;
                o_cmd.res.start = tag;
                if (inflight != '0) begin
                    o_cmd.run    = 1'b1;
                    o_cmd.base   = r_base;
                    o_cmd.cnt    = inflight;
                    o_cmd.res.pv = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_next <= '0;
            r_full <= 1'b0;
        end else if (o_push) begin
            r_base <= n_base;
            r_next <= n_next;
            r_full <= n_full;
        end
    end

endmodule

`default_nettype wire

### design/gbns_fifo.sv
// ---------------------------------------------------------------------------
// gbns_fifo
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module gbns_fifo
    import gbns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_qstat    o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_head     = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/gbns_back.sv
// ---------------------------------------------------------------------------
// gbns_back
// Executes queued commands: payload store, retransmit runs, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gbns_back
    import gbns_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_head,
    input  wire t_qstat i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_res        o_res
);

    logic [STORE_W-1:0] r_store [SEQ_SPACE];
    t_seq               r_idx;
    logic               r_out_valid;
    t_res               r_out;

    logic load;
    logic fire;
    logic run_last;
    t_seq rd_seq;
    t_res res_now;

    assign load     = !r_out_valid || i_ready;
    assign fire     = load && !i_qstat.empty;
    assign rd_seq   = seq_add(i_head.base, r_idx);
    assign run_last = (r_idx == (i_head.cnt - t_seq'(1)));
    assign o_pop    = fire && (!i_head.run || run_last);

    always_comb begin
        res_now = i_head.res;
        if (i_head.run) begin
            res_now.seq  = rd_seq;
            res_now.pay  = PAY_W'(r_store[rd_seq]);
            res_now.last = run_last;
            if (r_idx != '0) begin
                res_now.tcmd  = TMR_NONE;
                res_now.stop  = '0;
                res_now.start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr) begin
            r_store[i_head.res.seq] <= i_head.res.pay[STORE_W-1:0];
        end
        if (fire) begin
            r_out <= res_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_idx <= o_pop ? '0 : r_idx + 1'b1;
            end
            if (load) begin
                r_out_valid <= fire;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

### design/go_back_n_sender_unit.sv
// ---------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-n sender: send, ack and timeout items in, packet and timer items out.
// ---------------------------------------------------------------------------
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata, tuser (mode)
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata, tlast
//
// send, ack and unused-mode items each give one result in the back part
// timeout, n outstanding: n results, one store read per cycle unless stalled
// results pass through the command queue and then the output register
// reset is synchronous, active low; the payload store is not cleared
// input stalls only when the two-entry command queue is full
// ---------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_unit
    import gbns_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // payload[63:0], ack_seq[66:64], ack_ok[67], timer_tag[70:68]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // accepted[0], packet_valid[1], packet_seq[4:2], packet_payload[68:5],
    // timer_cmd[70:69], timer_stop_seq[73:71], timer_start_seq[76:74],
    // window_full[77]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    logic   push;
    logic   pop;
    t_cmd   push_cmd;
    t_cmd   head;
    t_qstat qstat;
    t_res   res;

    gbns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    gbns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    gbns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.full, res.start, res.stop, res.tcmd,
                           res.pay, res.seq, res.pv, res.acc};
    assign m_axis_tlast = res.last;

    a_run_carries_packets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.last |-> res.pv && res.acc)
        else $error("non-final result of a run without a packet");

    a_timer_only_if_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.tcmd != TMR_NONE) |-> res.acc)
        else $error("timer command on a refused item");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("command queue read while empty");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
